[hdl/snbp_pkg.sv]
// Shared constants, types and helpers for the SMS notification byte parser.
`timescale 1ns / 1ps
`default_nettype none

package snbp_pkg;

    // Capacities of the captured fields.
    localparam int PHONE_CHARS  = 13;
    localparam int MESSAGE_MAX  = 32;
    localparam int LINE_MAX     = 256;
    localparam int PREFIX_CHARS = 3;

    // Counter widths follow the capacities.
    localparam int PHONE_CW = $clog2(PHONE_CHARS + 1);
    localparam int MSG_CW   = $clog2(MESSAGE_MAX + 1);
    localparam int LINE_CW  = $clog2(LINE_MAX + 1);

    // Byte values the parser looks for.
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    // Operation codes on the input channel.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_REARM = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_LINE_MODE    = 1'b0;
    localparam logic CFG_STRIP_PREFIX = 1'b1;

    // Result kinds.
    localparam logic [2:0] KIND_PHONE_CHAR = 3'd0;
    localparam logic [2:0] KIND_MSG_CHAR   = 3'd1;
    localparam logic [2:0] KIND_MSG_DONE   = 3'd2;
    localparam logic [2:0] KIND_LINE_CHAR  = 3'd3;
    localparam logic [2:0] KIND_LINE_DONE  = 3'd4;

    typedef enum logic [3:0] {
        PH_WAIT_QUOTE = 4'b0001,
        PH_PHONE      = 4'b0010,
        PH_WAIT_LF    = 4'b0100,
        PH_MESSAGE    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] position;
        logic [7:0] char_out;
        logic [7:0] text_length;
        logic       overflowed;
    } t_result;

    // Length of stored text without its trailing CR, floored at zero and
    // saturated to eight bits.
    function automatic logic [7:0] text_len(input logic [15:0] count);
        logic [15:0] len;
        begin
            len = (count == 16'd0) ? 16'd0 : count - 16'd1;
            text_len = (len > 16'd255) ? 8'd255 : len[7:0];
        end
    endfunction

endpackage

`default_nettype wire

[hdl/sms_notification_byte_parser.sv]
// Top level of the SMS notification byte parser with its output stage.
// A result is registered: it enters the output register, or the skid register while that is full and stalled.
// Throughput: one byte beat per cycle while the input is not stalled; the per-byte decision is a single level of
// compare and count logic ahead of a result register backed by one skid register.
// Input stall rises only while the skid register holds a waiting result.
// Reset (i_rst_n low, synchronous) clears the phase, counts, flags, configuration
// and both result valids; result payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sms_notification_byte_parser
    import snbp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Input channel
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_op,
    input  wire  [7:0] i_rx_byte,
    // Result channel
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_position,
    output logic [7:0] o_char_out,
    output logic [7:0] o_text_length,
    output logic       o_overflowed,
    // Configuration write channel
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire        i_cfg_data
);

    // Configuration registers.
    logic r_line_mode;
    logic r_strip_prefix;

    // Parser state. SMS mode and line mode keep separate counters, but the
    // halted and overflow flags are shared between the two modes.
    t_phase              r_phase, n_phase;
    logic [PHONE_CW-1:0] r_phone_count, n_phone_count;
    logic [MSG_CW-1:0]   r_msg_count, n_msg_count;
    logic [LINE_CW-1:0]  r_line_count, n_line_count;
    logic                r_halted, n_halted;
    logic                r_ovf, n_ovf;

    // Output register and skid register.
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    logic    w_out_fire;

    // Configuration writes are always taken; the user must write only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    // The input side stalls only while a result sits in the skid register,
    // so a new beat can still be taken while the output register is stalled.
    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && !i_out_stall;

    // Per-byte decision: next state and the optional result for this beat.
    always_comb begin
        n_phase       = r_phase;
        n_phone_count = r_phone_count;
        n_msg_count   = r_msg_count;
        n_line_count  = r_line_count;
        n_halted      = r_halted;
        n_ovf         = r_ovf;
        w_res_valid   = 1'b0;
        w_res         = '0;

        if (i_op == OP_REARM) begin
            n_halted = 1'b0;
        end else if (r_halted) begin
            // Bytes are ignored until the block is rearmed.
        end else if (r_line_mode) begin
            if (i_rx_byte == LF_BYTE) begin
                w_res_valid       = 1'b1;
                w_res.kind        = KIND_LINE_DONE;
                w_res.text_length = text_len(16'(r_line_count));
                w_res.overflowed  = r_ovf;
                n_line_count      = '0;
                n_ovf             = 1'b0;
            end else if (r_line_count >= LINE_CW'(LINE_MAX)) begin
                n_ovf = 1'b1;
            end else begin
                w_res_valid      = 1'b1;
                w_res.kind       = KIND_LINE_CHAR;
                w_res.position   = 8'(r_line_count);
                w_res.char_out   = i_rx_byte;
                w_res.overflowed = r_ovf;
                n_line_count     = r_line_count + 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_WAIT_QUOTE: begin
                    if (i_rx_byte == QUOTE_BYTE) begin
                        n_phase = PH_PHONE;
                    end
                end
                PH_PHONE: begin
                    if (r_phone_count < PHONE_CW'(PHONE_CHARS)) begin
                        n_phone_count = r_phone_count + 1'b1;
                        // With stripping on, the country code is counted
                        // but not reported, and numbering restarts after it.
                        if (!r_strip_prefix) begin
                            w_res_valid    = 1'b1;
                            w_res.position = 8'(r_phone_count);
                        end else if (r_phone_count >= PHONE_CW'(PREFIX_CHARS)) begin
                            w_res_valid    = 1'b1;
                            w_res.position = 8'(r_phone_count) - 8'(PREFIX_CHARS);
                        end
                        w_res.kind       = KIND_PHONE_CHAR;
                        w_res.char_out   = i_rx_byte;
                        w_res.overflowed = r_ovf;
                    end else begin
                        // The byte after the number (the closing quote) is dropped.
                        n_phase = PH_WAIT_LF;
                    end
                end
                PH_WAIT_LF: begin
                    if (i_rx_byte == LF_BYTE) begin
                        n_phase = PH_MESSAGE;
                    end
                end
                PH_MESSAGE: begin
                    if (i_rx_byte == LF_BYTE) begin
                        w_res_valid       = 1'b1;
                        w_res.kind        = KIND_MSG_DONE;
                        w_res.text_length = text_len(16'(r_msg_count));
                        w_res.overflowed  = r_ovf;
                        n_phase           = PH_WAIT_QUOTE;
                        n_phone_count     = '0;
                        n_msg_count       = '0;
                        n_ovf             = 1'b0;
                        n_halted          = 1'b1;
                    end else if (r_msg_count >= MSG_CW'(MESSAGE_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_res_valid      = 1'b1;
                        w_res.kind       = KIND_MSG_CHAR;
                        w_res.position   = 8'(r_msg_count);
                        w_res.char_out   = i_rx_byte;
                        w_res.overflowed = r_ovf;
                        n_msg_count      = r_msg_count + 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_WAIT_QUOTE;
                end
            endcase
        end
    end

    // Configuration and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode    <= 1'b0;
            r_strip_prefix <= 1'b0;
            r_phase        <= PH_WAIT_QUOTE;
            r_phone_count  <= '0;
            r_msg_count    <= '0;
            r_line_count   <= '0;
            r_halted       <= 1'b0;
            r_ovf          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_LINE_MODE:    r_line_mode    <= i_cfg_data;
                    CFG_STRIP_PREFIX: r_strip_prefix <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_phase       <= n_phase;
                r_phone_count <= n_phone_count;
                r_msg_count   <= n_msg_count;
                r_line_count  <= n_line_count;
                r_halted      <= n_halted;
                r_ovf         <= n_ovf;
            end
        end
    end

    // Output register with skid. A new result goes straight to the output
    // register when it is free or being emptied this cycle, otherwise it is
    // parked in the skid register, which refills the output next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept && w_res_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_accept && w_res_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_position    = r_out.position;
    assign o_char_out    = r_out.char_out;
    assign o_text_length = r_out.text_length;
    assign o_overflowed  = r_out.overflowed;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the SMS notification byte parser.
`timescale 1ns / 1ps

module tb;
    import snbp_pkg::*;

    // The watchdog gives up after this many cycles in which no beat moves on any channel.
    localparam int WATCHDOG_LIMIT = 5000;
    // Length of the deliberate output hold-off that forces the block to back up.
    localparam int LONG_HOLD = 400;
    // Cycles allowed for a beat that causes no result to clear the block.
    localparam int SETTLE_CYCLES = 6;
    // Random beats per phase, and the number of phases.
    localparam int PHASE_ITEMS = 155;
    localparam int NUM_PHASES = 8;

    // One beat of the input channel.
    typedef struct packed {
        logic       op;
        logic [7:0] rx;
    } t_byte_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       beat_op = OP_BYTE;
    logic [7:0] beat_byte = 8'h00;
    logic       in_stall;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] res_kind;
    logic [7:0] res_position;
    logic [7:0] res_char;
    logic [7:0] res_length;
    logic       res_overflowed;

    logic       cfg_valid = 1'b0;
    logic       cfg_index = CFG_LINE_MODE;
    logic       cfg_data = 1'b0;
    logic       cfg_ready;

    sms_notification_byte_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (beat_op),
        .i_rx_byte     (beat_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (res_kind),
        .o_position    (res_position),
        .o_char_out    (res_char),
        .o_text_length (res_length),
        .o_overflowed  (res_overflowed),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Beats waiting to be offered, and the results the parser should produce, oldest first.
    t_byte_beat pending_beats[$];
    t_result    expected_results[$];

    int beats_queued = 0;
    int beats_sent = 0;
    int stim_items = 0;
    int mismatches = 0;
    int results_seen = 0;
    int idle_run = 0;

    // Idling controls, changed by the stimulus process between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;

    bit beat_taken = 1'b0;

    // Shadow copy of the parser: configuration and parse state.
    logic       cfg_line_mode = 1'b0;
    logic       cfg_strip = 1'b0;
    t_phase     sms_phase = PH_WAIT_QUOTE;
    logic [3:0] phone_cnt = '0;
    logic [5:0] msg_cnt = '0;
    logic [8:0] line_cnt = '0;
    logic       halted = 1'b0;
    logic       overflow_seen = 1'b0;

    // Content length on completion: the stored bytes minus the CR, never below zero,
    // and clipped to what eight bits can report.
    function automatic logic [7:0] content_len(input int stored);
        if (stored <= 1)
            return 8'd0;
        if (stored - 1 > 255)
            return 8'd255;
        return 8'(stored - 1);
    endfunction

    // Advances the shadow parser by one accepted beat and queues the result it causes.
    function automatic void parse_beat(input logic op, input logic [7:0] b);
        t_result r;
        bit      emit;
        int      idx;
        r = '0;
        emit = 1'b0;
        if (op == OP_REARM) begin
            halted = 1'b0;
        end else if (!halted) begin
            if (cfg_line_mode) begin
                // Line mode: everything up to a line feed is content, the line feed closes it.
                if (b == LF_BYTE) begin
                    r.kind = KIND_LINE_DONE;
                    r.text_length = content_len(int'(line_cnt));
                    r.overflowed = overflow_seen;
                    emit = 1'b1;
                    line_cnt = '0;
                    overflow_seen = 1'b0;
                end else if (line_cnt >= LINE_MAX) begin
                    overflow_seen = 1'b1;
                end else begin
                    r.kind = KIND_LINE_CHAR;
                    r.position = line_cnt[7:0];
                    r.char_out = b;
                    r.overflowed = overflow_seen;
                    emit = 1'b1;
                    line_cnt = line_cnt + 9'd1;
                end
            end else begin
                case (sms_phase)
                    PH_WAIT_QUOTE: begin
                        if (b == QUOTE_BYTE)
                            sms_phase = PH_PHONE;
                    end
                    PH_PHONE: begin
                        if (phone_cnt < PHONE_CHARS) begin
                            idx = int'(phone_cnt);
                            phone_cnt = phone_cnt + 4'd1;
                            // The country code is captured but not reported when stripping.
                            if (!(cfg_strip && idx < PREFIX_CHARS)) begin
                                if (cfg_strip)
                                    idx = idx - PREFIX_CHARS;
                                r.kind = KIND_PHONE_CHAR;
                                r.position = 8'(idx);
                                r.char_out = b;
                                r.overflowed = overflow_seen;
                                emit = 1'b1;
                            end
                        end else begin
                            // The byte right after the number is dropped.
                            sms_phase = PH_WAIT_LF;
                        end
                    end
                    PH_WAIT_LF: begin
                        if (b == LF_BYTE)
                            sms_phase = PH_MESSAGE;
                    end
                    default: begin
                        if (b == LF_BYTE) begin
                            r.kind = KIND_MSG_DONE;
                            r.text_length = content_len(int'(msg_cnt));
                            r.overflowed = overflow_seen;
                            emit = 1'b1;
                            sms_phase = PH_WAIT_QUOTE;
                            phone_cnt = '0;
                            msg_cnt = '0;
                            overflow_seen = 1'b0;
                            halted = 1'b1;
                        end else if (msg_cnt >= MESSAGE_MAX) begin
                            overflow_seen = 1'b1;
                        end else begin
                            r.kind = KIND_MSG_CHAR;
                            r.position = 8'(msg_cnt);
                            r.char_out = b;
                            r.overflowed = overflow_seen;
                            emit = 1'b1;
                            msg_cnt = msg_cnt + 6'd1;
                        end
                    end
                endcase
            end
        end
        if (emit)
            expected_results.push_back(r);
    endfunction

    // Input driver, edge one: note whether the offered beat was taken and predict it.
    always @(posedge i_clk) begin
        beat_taken = in_valid && !in_stall;
        if (beat_taken) begin
            parse_beat(beat_op, beat_byte);
            beats_sent++;
        end
    end

    // Input driver, edge two: a beat stays on the port until it is taken; after that the
    // next one is offered or the sender idles. The choice never looks at the stall.
    always @(negedge i_clk) begin
        t_byte_beat nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || beat_taken) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_beats.pop_front();
                in_valid <= 1'b1;
                beat_op <= nxt.op;
                beat_byte <= nxt.rx;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result stall: either a long hold-off on request, or random stalls at the phase rate.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor: every accepted result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result %0d arrived with nothing expected: kind=%0d pos=%0d",
                             results_seen, res_kind, res_position);
            end else begin
                want = expected_results.pop_front();
                if (res_kind !== want.kind || res_position !== want.position ||
                    res_char !== want.char_out || res_length !== want.text_length ||
                    res_overflowed !== want.overflowed) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb: result %0d expected kind=%0d pos=%0d char=%02h len=%0d ovf=%0d",
                                 results_seen, want.kind, want.position, want.char_out,
                                 want.text_length, want.overflowed);
                        $display("tb: result %0d got      kind=%0d pos=%0d char=%02h len=%0d ovf=%0d",
                                 results_seen, res_kind, res_position, res_char,
                                 res_length, res_overflowed);
                    end
                end
            end
        end
    end

    // Watchdog: a run in which no beat moves on any channel for too long has hung.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Writes one configuration register; the block is idle whenever this is called.
    task automatic write_reg(input logic idx, input logic val);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        if (idx == CFG_LINE_MODE)
            cfg_line_mode = val;
        else
            cfg_strip = val;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Returns once every queued beat is taken, every result has arrived, and beats that
    // cause no result have had time to leave the pipeline.
    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (beats_sent != beats_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_beats(input t_byte_beat seq[$], input int ignored);
        foreach (seq[i]) begin
            pending_beats.push_back(seq[i]);
            beats_queued++;
        end
        stim_items += seq.size() - ignored;
    endtask

    function automatic logic [7:0] byte_except(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] phone_digit();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return 8'("0" + $urandom_range(9));
    endfunction

    // A notification as the modem sends it: optional chatter, quoted number, the rest of
    // the header, the text and its line feed, then a rearm. A broken one is cut short.
    task automatic queue_sms_notice(input bit broken);
        t_byte_beat seq[$];
        int         n;
        int         ignored;
        int         cut;
        ignored = 0;
        n = $urandom_range(3);
        repeat (n) seq.push_back({OP_BYTE, byte_except(QUOTE_BYTE)});
        seq.push_back({OP_BYTE, QUOTE_BYTE});
        repeat (PHONE_CHARS) seq.push_back({OP_BYTE, phone_digit()});
        seq.push_back({OP_BYTE, ($urandom_range(1) ? QUOTE_BYTE : 8'($urandom_range(255)))});
        n = $urandom_range(5);
        repeat (n) seq.push_back({OP_BYTE, byte_except(LF_BYTE)});
        seq.push_back({OP_BYTE, LF_BYTE});
        // Now and then the text is long enough to run past the message buffer.
        n = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(20);
        repeat (n) seq.push_back({OP_BYTE, byte_except(LF_BYTE)});
        if ($urandom_range(3) != 0)
            seq.push_back({OP_BYTE, 8'h0D});
        seq.push_back({OP_BYTE, LF_BYTE});
        if (broken) begin
            cut = $urandom_range(seq.size() - 1);
            while (seq.size() > cut)
                void'(seq.pop_back());
            if ($urandom_range(1))
                seq.push_back({OP_REARM, 8'($urandom_range(255))});
        end else begin
            // Bytes after completion are ignored until the rearm.
            if ($urandom_range(5) == 0) begin
                ignored = $urandom_range(1, 3);
                repeat (ignored) seq.push_back({OP_BYTE, 8'($urandom_range(255))});
            end
            seq.push_back({OP_REARM, 8'($urandom_range(255))});
            if ($urandom_range(7) == 0)
                seq.push_back({OP_REARM, 8'($urandom_range(255))});
        end
        queue_beats(seq, ignored);
    endtask

    task automatic queue_line(input int len);
        t_byte_beat seq[$];
        repeat (len) seq.push_back({OP_BYTE, byte_except(LF_BYTE)});
        if ($urandom_range(3) != 0)
            seq.push_back({OP_BYTE, 8'h0D});
        seq.push_back({OP_BYTE, LF_BYTE});
        queue_beats(seq, 0);
    endtask

    // Unstructured traffic: any byte, line feeds and quotes included, with stray rearms.
    task automatic queue_noise(input int len);
        t_byte_beat seq[$];
        repeat (len) begin
            if ($urandom_range(7) == 0)
                seq.push_back({OP_REARM, 8'($urandom_range(255))});
            else if ($urandom_range(5) == 0)
                seq.push_back({OP_BYTE, ($urandom_range(1) ? LF_BYTE : QUOTE_BYTE)});
            else
                seq.push_back({OP_BYTE, 8'($urandom_range(255))});
        end
        queue_beats(seq, 0);
    endtask

    // Stimulus: reset, a directed pass over the corner cases, then random phases that walk
    // through every register setting and every idling pattern.
    initial begin
        t_byte_beat seq[$];
        int         phase_end;
        logic [2:0] pb;
        int         pick;
        bit         paused;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed, SMS mode from reset. A rearm while running does nothing. The number
        // holds the extreme byte values and both framing bytes, which must be taken as
        // plain digits there. The text is all-ones, zero and CR.
        seq.push_back({OP_REARM, 8'hFF});
        seq.push_back({OP_BYTE, QUOTE_BYTE});
        seq.push_back({OP_BYTE, 8'h00});
        seq.push_back({OP_BYTE, 8'hFF});
        seq.push_back({OP_BYTE, QUOTE_BYTE});
        seq.push_back({OP_BYTE, LF_BYTE});
        for (int i = 0; i < PHONE_CHARS - 4; i++)
            seq.push_back({OP_BYTE, 8'("1" + i)});
        seq.push_back({OP_BYTE, QUOTE_BYTE});
        seq.push_back({OP_BYTE, LF_BYTE});
        seq.push_back({OP_BYTE, 8'hFF});
        seq.push_back({OP_BYTE, 8'h00});
        seq.push_back({OP_BYTE, 8'h0D});
        seq.push_back({OP_BYTE, LF_BYTE});
        // The parser is halted now, so this byte must vanish.
        seq.push_back({OP_BYTE, 8'h7A});
        queue_beats(seq, 1);
        seq.delete();
        wait_quiet();

        // Directed, line mode. The halt carries over the mode switch; after the rearm an
        // empty line reports a zero length.
        write_reg(CFG_LINE_MODE, 1'b1);
        seq.push_back({OP_BYTE, 8'h71});
        seq.push_back({OP_REARM, 8'h00});
        seq.push_back({OP_BYTE, LF_BYTE});
        seq.push_back({OP_BYTE, 8'h68});
        seq.push_back({OP_BYTE, LF_BYTE});
        queue_beats(seq, 1);
        seq.delete();
        wait_quiet();

        for (int p = 0; p < NUM_PHASES; p++) begin
            pb = 3'(p);
            // Each pair of line mode and prefix stripping comes up twice.
            write_reg(CFG_LINE_MODE, pb[0]);
            write_reg(CFG_STRIP_PREFIX, pb[1] ^ pb[2]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            // In one full-rate phase the result side holds off for a long time while beats
            // keep coming, so the block fills up and stalls its input.
            if (p == 4)
                hold_req = ~hold_req;
            phase_end = stim_items + PHASE_ITEMS;
            paused = 1'b0;
            while (stim_items < phase_end) begin
                // Once, halfway through the third phase only, the sender waits for everything to drain.
                if (p == 2 && !paused && stim_items > phase_end - PHASE_ITEMS / 2) begin
                    wait_quiet();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (cfg_line_mode) begin
                    if (pick < 3)
                        queue_line($urandom_range(250, 262));
                    else if (pick < 85)
                        queue_line($urandom_range(20));
                    else
                        queue_noise($urandom_range(1, 8));
                end else begin
                    if (pick < 75)
                        queue_sms_notice(1'b0);
                    else if (pick < 90)
                        queue_sms_notice(1'b1);
                    else
                        queue_noise($urandom_range(1, 8));
                end
            end
            wait_quiet();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
